// ===== sv/bctd_pkg.sv =====
`timescale 1ns / 1ps
package bctd_pkg;

  localparam int unsigned MAX_SIDE_DEF = 8192;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // texture_format codes (code three decodes as DXT5)
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // register indexes, byte address 4*index
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] TRANSPARENT_IDX = 2'd3;

  // partial results of one block between the two front stages
  typedef struct packed {
    logic [12:0]       bx;
    logic [12:0]       by;
    logic [1:0]        last_col;
    logic [1:0]        last_row;
    logic              empty;
    logic [1:0]        fmt;
    logic              three;
    logic [2:0][7:0]   e0;
    logic [2:0][7:0]   e1;
    logic [2:0][9:0]   s2;
    logic [2:0][9:0]   s3;
    logic [2:0][8:0]   sm;
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic              agt;
    logic [5:0][10:0]  as;
    logic [63:0]       aw;
    logic [31:0]       cidx;
  } bctd_sums_t;

  // one decoded block waiting for the texel walker
  typedef struct packed {
    logic [12:0]          bx;
    logic [12:0]          by;
    logic [1:0]           last_col;
    logic [1:0]           last_row;
    logic [1:0]           fmt;
    logic                 three;
    logic [3:0][2:0][7:0] pal;
    logic [7:0][7:0]      atab;
    logic [63:0]          aw;
    logic [31:0]          cidx;
  } bctd_entry_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } bctd_texel_t;

  // v*255/31 truncated, by reciprocal 8457/2^18
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd2156535;
    return p[25:18];
  endfunction

  // v*255/63 truncated, by reciprocal 16645/2^20
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [29:0] p;
    p = 30'(v) * 30'd4244475;
    return p[27:20];
  endfunction

  // x/3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x/5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd3277;
    return p[21:14];
  endfunction

  // x/7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd2341;
    return p[21:14];
  endfunction

endpackage

// ===== sv/bc_texture_block_decoder.sv =====
// channel   dir  handshake                    payload
// in_       in   in_tvalid / in_tready        in_tdata: one compressed 4x4 block
// out_      out  out_tvalid / out_tready      out_tdata + out_tlast: one texel
// cfg_      in   psel, penable, pready        format, width, height registers
//
// One texel leaves per cycle while out_tready is high and a block is queued; a
// block yields its texels inside the image (1 to 16), walked from the block queue.
// Blocks wholly outside the image are dropped in the front and yield no texels.
// A block passes front stages one and two, then the queue; texels leave registered.
// Synchronous reset clears the registers to DXT1, 4x4 and empties the pipeline.
// out_tready low holds the output; the front keeps accepting until its two-entry
// queue and both front stages are full.
`timescale 1ns / 1ps
module bc_texture_block_decoder import bctd_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,   // block_col, block_row, alpha_word, color_word, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // pixel_x, pixel_y, red, green, blue, alpha, pad
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [1:0]  fmt_r;
  logic [13:0] width_r;
  logic [13:0] height_r;
  logic        cfg_wr;

  logic        push;
  bctd_entry_t push_entry;
  logic        q_full;
  logic        head_valid;
  bctd_entry_t head;
  logic        pop;
  bctd_texel_t texel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_DXT1;
      width_r  <= 14'd4;
      height_r <= 14'd4;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FORMAT: fmt_r    <= cfg_pwdata[1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[13:0];
        REG_HEIGHT: height_r <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FORMAT: cfg_prdata = 32'(fmt_r);
      REG_WIDTH:  cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      default:    cfg_prdata = 32'd0;
    endcase
  end

  bctd_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .block_col  (in_tdata[10:0]),
    .block_row  (in_tdata[21:11]),
    .alpha_word (in_tdata[85:22]),
    .color_word (in_tdata[149:86]),
    .fmt        (fmt_r),
    .img_w      (width_r),
    .img_h      (height_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bctd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  bctd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .texel      (texel)
  );

  assign out_tdata = {6'd0, texel.a, texel.b, texel.g, texel.r, texel.y, texel.x};
  assign out_tlast = texel.last;

endmodule

// ===== sv/bctd_front.sv =====
`timescale 1ns / 1ps
module bctd_front import bctd_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] block_col,
  input  logic [10:0] block_row,
  input  logic [63:0] alpha_word,
  input  logic [63:0] color_word,
  input  logic [1:0]  fmt,
  input  logic [13:0] img_w,
  input  logic [13:0] img_h,
  input  logic        q_full,
  output logic        push,
  output bctd_entry_t push_entry
);

  logic        f1_v_r;
  logic [10:0] f1_col_r;
  logic [10:0] f1_row_r;
  logic [63:0] f1_aw_r;
  logic [63:0] f1_cw_r;
  logic        f2_v_r;
  bctd_sums_t  f2_r;
  bctd_sums_t  f2_nxt;
  logic        f2_leave;
  logic        f2_take;

  logic [15:0]     c0;
  logic [15:0]     c1;
  logic [2:0][7:0] e0;
  logic [2:0][7:0] e1;
  logic [14:0]     wlim;
  logic [14:0]     hlim;
  logic [14:0]     dx;
  logic [14:0]     dy;
  logic            col_out;
  logic            row_out;

  // a block wholly outside the image just drains out of stage two
  assign f2_leave = f2_v_r && (f2_r.empty || !q_full);
  assign f2_take  = !f2_v_r || f2_leave;
  assign in_ready = !f1_v_r || f2_take;
  assign push     = f2_v_r && !f2_r.empty && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (in_ready) f1_v_r <= in_valid;
      if (f2_take)  f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_col_r <= block_col;
      f1_row_r <= block_row;
      f1_aw_r  <= alpha_word;
      f1_cw_r  <= color_word;
    end
    if (f2_take && f1_v_r) f2_r <= f2_nxt;
  end

  // clip limits
  always_comb begin
    wlim    = ({1'b0, img_w} < 15'(MAX_SIDE)) ? {1'b0, img_w} : 15'(MAX_SIDE);
    hlim    = ({1'b0, img_h} < 15'(MAX_SIDE)) ? {1'b0, img_h} : 15'(MAX_SIDE);
    col_out = {2'b00, f1_col_r, 2'b00} >= wlim;
    row_out = {2'b00, f1_row_r, 2'b00} >= hlim;
    dx      = wlim - {2'b00, f1_col_r, 2'b00};
    dy      = hlim - {2'b00, f1_row_r, 2'b00};
  end

  // stage one to two: endpoint expansion, interpolation sums, clip
  always_comb begin
    c0    = f1_cw_r[15:0];
    c1    = f1_cw_r[31:16];
    e0[0] = exp5(c0[15:11]);
    e0[1] = exp6(c0[10:5]);
    e0[2] = exp5(c0[4:0]);
    e1[0] = exp5(c1[15:11]);
    e1[1] = exp6(c1[10:5]);
    e1[2] = exp5(c1[4:0]);

    f2_nxt          = '0;
    f2_nxt.bx       = {f1_col_r, 2'b00};
    f2_nxt.by       = {f1_row_r, 2'b00};
    f2_nxt.empty    = col_out || row_out;
    f2_nxt.last_col = (dx >= 15'd4) ? 2'd3 : dx[1:0] - 2'd1;
    f2_nxt.last_row = (dy >= 15'd4) ? 2'd3 : dy[1:0] - 2'd1;
    f2_nxt.fmt      = fmt;
    f2_nxt.three    = (fmt == FMT_DXT1) && (c0 <= c1);
    f2_nxt.e0       = e0;
    f2_nxt.e1       = e1;
    for (int k = 0; k < 3; k++) begin
      f2_nxt.s2[k] = 10'({e0[k], 1'b0}) + 10'(e1[k]);
      f2_nxt.s3[k] = 10'(e0[k]) + 10'({e1[k], 1'b0});
      f2_nxt.sm[k] = 9'(e0[k]) + 9'(e1[k]);
    end

    f2_nxt.a0  = f1_aw_r[7:0];
    f2_nxt.a1  = f1_aw_r[15:8];
    f2_nxt.agt = f1_aw_r[7:0] > f1_aw_r[15:8];
    for (int i = 0; i < 6; i++) begin
      if (f1_aw_r[7:0] > f1_aw_r[15:8]) begin
        f2_nxt.as[i] = 11'(f1_aw_r[7:0]) * 11'(6 - i) + 11'(f1_aw_r[15:8]) * 11'(i + 1);
      end else if (i < 4) begin
        f2_nxt.as[i] = 11'(f1_aw_r[7:0]) * 11'(4 - i) + 11'(f1_aw_r[15:8]) * 11'(i + 1);
      end else begin
        f2_nxt.as[i] = '0;
      end
    end
    f2_nxt.aw   = f1_aw_r;
    f2_nxt.cidx = f1_cw_r[63:32];
  end

  // stage two into the queue: divisions by reciprocal
  always_comb begin
    push_entry          = '0;
    push_entry.bx       = f2_r.bx;
    push_entry.by       = f2_r.by;
    push_entry.last_col = f2_r.last_col;
    push_entry.last_row = f2_r.last_row;
    push_entry.fmt      = f2_r.fmt;
    push_entry.three    = f2_r.three;
    push_entry.aw       = f2_r.aw;
    push_entry.cidx     = f2_r.cidx;
    for (int k = 0; k < 3; k++) begin
      push_entry.pal[0][k] = f2_r.e0[k];
      push_entry.pal[1][k] = f2_r.e1[k];
      if (f2_r.three) begin
        push_entry.pal[2][k] = f2_r.sm[k][8:1];
        push_entry.pal[3][k] = 8'd0;
      end else begin
        push_entry.pal[2][k] = div3(f2_r.s2[k]);
        push_entry.pal[3][k] = div3(f2_r.s3[k]);
      end
    end
    push_entry.atab[0] = f2_r.a0;
    push_entry.atab[1] = f2_r.a1;
    for (int i = 0; i < 6; i++) begin
      if (f2_r.agt) begin
        push_entry.atab[i + 2] = div7(f2_r.as[i]);
      end else if (i < 4) begin
        push_entry.atab[i + 2] = div5(f2_r.as[i]);
      end else if (i == 4) begin
        push_entry.atab[i + 2] = 8'd0;
      end else begin
        push_entry.atab[i + 2] = 8'd255;
      end
    end
  end

endmodule

// ===== sv/bctd_queue.sv =====
`timescale 1ns / 1ps
module bctd_queue import bctd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bctd_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        head_valid,
  output bctd_entry_t head
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  bctd_entry_t   mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] cnt_nxt;

  assign full       = cnt_r == CW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== sv/bctd_back.sv =====
`timescale 1ns / 1ps
module bctd_back import bctd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  bctd_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output bctd_texel_t texel
);

  logic [1:0]  cx_r;
  logic [1:0]  ry_r;
  logic        out_v_r;
  bctd_texel_t texel_r;
  logic [1:0]  cx_nxt;
  logic [1:0]  ry_nxt;
  logic        out_v_nxt;
  bctd_texel_t texel_nxt;
  logic        load;
  logic        end_col;
  logic        end_blk;
  logic [3:0]  ti;
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  aidx;

  assign load    = head_valid && (!out_v_r || out_ready);
  assign end_col = cx_r == head.last_col;
  assign end_blk = end_col && (ry_r == head.last_row);
  assign pop     = load && end_blk;
  assign ti      = {ry_r, cx_r};

  always_comb begin
    ci   = head.cidx[{ti, 1'b0} +: 2];
    nib  = head.aw[{ti, 2'b00} +: 4];
    aidx = head.aw[6'd16 + 6'(ti) * 6'd3 +: 3];

    texel_nxt      = '0;
    texel_nxt.x    = head.bx + 13'(cx_r);
    texel_nxt.y    = head.by + 13'(ry_r);
    texel_nxt.r    = head.pal[ci][0];
    texel_nxt.g    = head.pal[ci][1];
    texel_nxt.b    = head.pal[ci][2];
    texel_nxt.last = end_blk;
    case (head.fmt)
      FMT_DXT1: texel_nxt.a = (head.three && ci == TRANSPARENT_IDX) ? 8'd0 : 8'd255;
      FMT_DXT3: texel_nxt.a = {nib, nib};
      default:  texel_nxt.a = head.atab[aidx];
    endcase
  end

  // walk the in-image rectangle of the head block, raster order
  always_comb begin
    cx_nxt    = cx_r;
    ry_nxt    = ry_r;
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
      if (end_col) begin
        cx_nxt = 2'd0;
        ry_nxt = end_blk ? 2'd0 : ry_r + 2'd1;
      end else begin
        cx_nxt = cx_r + 2'd1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= 2'd0;
      ry_r    <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      cx_r    <= cx_nxt;
      ry_r    <= ry_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) texel_r <= texel_nxt;
  end

  assign out_valid = out_v_r;
  assign texel     = texel_r;

endmodule

// ===== sv/bctd_checker.sv =====
`timescale 1ns / 1ps
module bctd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:58] == 6'd0)
    else $error("padding bits of out_tdata not zero");

  // a valid item carries no unknown bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown(out_tdata) && !$isunknown(out_tlast))
    else $error("unknown bits on a valid output item");

  a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind bc_texture_block_decoder bctd_checker u_bctd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
